// ===== rtl/keyframe_index_builder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Keyframe index builder assertion macros
// Concurrent assertion wrappers. Defining ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_INDEX_BUILDER_TOP_ASSERT_SVH
`define KEYFRAME_INDEX_BUILDER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define KIB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("keyframe index builder: assertion failed");
`define KIB_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyframe index builder: implication failed");
`else
`define KIB_ASSERT(name, clk, rst_n, prop)
`define KIB_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/kib_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyframe index builder package
// Stream constants, result record and queue types shared by the block.
// ----------------------------------------------------------------------------
package kib_pkg;

  localparam int unsigned HEADER_WINDOW = 50;

  localparam logic [31:0] TAG_VIDEO = 32'h4448_5054;
  localparam logic [31:0] TAG_AUDIO = 32'h0000_01F0;
  localparam logic [31:0] SC_KEY    = 32'h0000_0100;
  localparam logic [31:0] SC_PRED   = 32'h0000_01B6;
  localparam logic [31:0] SC_TIME   = 32'h0000_01B3;
  localparam logic [31:0] SC_RATE   = 32'h0000_01B2;

  localparam logic [7:0] RATE_MAX         = 8'd150;
  localparam logic [7:0] RATE_WILD        = 8'hFF;
  localparam logic [7:0] RATE_WILD_FPS    = 8'd1;
  localparam logic [7:0] RATE_DEFAULT_FPS = 8'd25;

  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned RES_AW    = $clog2(RES_DEPTH);
  localparam int unsigned RES_CW    = $clog2(RES_DEPTH + 1);
  localparam int unsigned IN_SLACK  = RES_DEPTH - 4;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET  = 1'b1;

  localparam int unsigned RES_DATA_W = 156;
  localparam int unsigned TDATA_W    = 160;

  typedef enum logic [1:0] {
    KIND_KEY       = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_NO_FRAMES = 2'd2,
    KIND_BAD_TAG   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] frame_position;
    logic [31:0] frame_number;
    logic [31:0] frame_length;
    logic [5:0]  hour_code;
    logic [6:0]  minute_code;
    logic [6:0]  second_code;
    logic [7:0]  frame_rate;
    logic [31:0] total_frames;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } res_push_t;

  typedef struct packed {
    logic [RES_CW-1:0] level;
  } fifo_stat_t;

endpackage

// ===== rtl/kib_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Keyframe index builder result queue
// Small queue that takes up to two result records per cycle and hands one
// record per beat to the output stream.
// ----------------------------------------------------------------------------
module kib_result_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kib_pkg::res_push_t     push_i,
  input  logic                   pop_i,
  output kib_pkg::result_t       head_o,
  output logic                   valid_o,
  output kib_pkg::fifo_stat_t    stat_o
);
  import kib_pkg::*;

  result_t           mem_q [RES_DEPTH];
  logic [RES_AW-1:0] wr_q;
  logic [RES_AW-1:0] rd_q;
  logic [RES_CW-1:0] level_q;
  logic              pop;

  assign pop = pop_i && (level_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + RES_AW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_q + RES_AW'(push_i.count);
      rd_q    <= rd_q + RES_AW'(pop);
      level_q <= level_q + RES_CW'(push_i.count) - RES_CW'(pop);
    end
  end

  assign head_o       = mem_q[rd_q];
  assign valid_o      = (level_q != '0);
  assign stat_o.level = level_q;

endmodule

// ===== rtl/kib_core.sv =====
// ----------------------------------------------------------------------------
// Keyframe index builder frame parser
// Per-byte state update: frame header decode, key frame detection, header
// scan for time code and frame rate, and result record generation.
// ----------------------------------------------------------------------------
module kib_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_first_i,
  input  logic [31:0]         stream_length_i,
  input  logic [31:0]         start_offset_i,
  output kib_pkg::res_push_t  push_o
);
  import kib_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_VTAG   = 3'd2;
  localparam logic [2:0] PH_KEY    = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  localparam logic [5:0]  IDX_TAG_LAST  = 6'd3;
  localparam logic [5:0]  IDX_LEN_LAST  = 6'd7;
  localparam logic [31:0] OFF_CODE_LAST = 32'd11;

  typedef struct packed {
    logic [31:0] start;
    logic [63:0] hdr;
    logic [31:0] left;
    logic [31:0] sc;
    logic [5:0]  scan_cnt;
    logic        scan_on;
    logic [1:0]  tcap;
    logic [2:0]  rcap;
  } frm_t;

  typedef struct packed {
    logic [31:0] num;
    logic [5:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [7:0]  rate;
  } ent_t;

  function automatic frm_t fresh_frame(input logic [31:0] start);
    frm_t f;
    f       = '0;
    f.start = start;
    f.sc    = '1;
    return f;
  endfunction

  function automatic logic fits(input logic [32:0] pos, input logic [31:0] limit);
    return ({1'b0, pos} + 34'(HEADER_WINDOW)) <= {2'b00, limit};
  endfunction

  logic [2:0]  phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] count_q, count_d;
  frm_t        frm_q, frm_d;
  ent_t        ent_q, ent_d;

  logic        run;
  logic        hit_end;
  logic        fin;
  logic        bad_tag;
  logic        key_out;
  logic        video;
  logic [5:0]  idx;
  logic [31:0] off;
  logic [31:0] len;
  logic [32:0] next_pos;
  logic [7:0]  t0, t1, t2;
  result_t     key_rec, fin_rec, bad_rec;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    count_d  = count_q;
    frm_d    = frm_q;
    ent_d    = ent_q;
    run      = 1'b0;
    hit_end  = 1'b0;
    fin      = 1'b0;
    bad_tag  = 1'b0;
    key_out  = 1'b0;
    video    = 1'b0;
    idx      = frm_q.scan_cnt;
    len      = '0;
    next_pos = '0;
    t0       = '0;
    t1       = '0;
    t2       = '0;
    key_rec  = '0;

    if (in_valid_i) begin
      if (in_first_i) begin
        pos_d   = start_offset_i;
        count_d = '0;
        ent_d   = '0;
        frm_d   = fresh_frame(start_offset_i);
        phase_d = PH_HEADER;
        if (!fits({1'b0, start_offset_i}, stream_length_i)) begin
          fin = 1'b1;
        end else begin
          run = 1'b1;
        end
      end else if (phase_q != PH_IDLE) begin
        pos_d = pos_q + 32'd1;
        run   = 1'b1;
      end
    end

    off = pos_d - frm_d.start;

    if (run) begin
      unique case (phase_d)
        PH_HEADER: begin
          idx            = frm_d.scan_cnt;
          frm_d.hdr      = {frm_d.hdr[55:0], in_byte_i};
          frm_d.scan_cnt = frm_d.scan_cnt + 6'd1;
          if (idx == IDX_TAG_LAST) begin
            if (frm_d.hdr[31:0] != TAG_VIDEO && frm_d.hdr[31:0] != TAG_AUDIO) begin
              bad_tag = 1'b1;
              phase_d = PH_IDLE;
            end
          end else if (idx == IDX_LEN_LAST) begin
            video = (frm_d.hdr[63:32] == TAG_VIDEO);
            len   = video ? {frm_d.hdr[7:0], frm_d.hdr[15:8],
                             frm_d.hdr[23:16], frm_d.hdr[31:24]}
                          : {16'h0000, frm_d.hdr[23:16], frm_d.hdr[31:24]};
            if ((({2'b00, frm_d.start} + {2'b00, len} + 34'd8) > {2'b00, stream_length_i})
                || (video && (len > stream_length_i))) begin
              fin = 1'b1;
            end else begin
              frm_d.left = len;
              frm_d.sc   = '1;
              phase_d    = (video && (len >= 32'd4)) ? PH_VTAG : PH_SKIP;
              hit_end    = (len == 32'd0);
            end
          end
        end
        PH_VTAG: begin
          frm_d.sc   = {frm_d.sc[23:0], in_byte_i};
          frm_d.left = frm_d.left - 32'd1;
          if (off == OFF_CODE_LAST) begin
            if (frm_d.sc == SC_KEY) begin
              ent_d         = '0;
              ent_d.num     = count_d;
              count_d       = count_d + 32'd1;
              frm_d.scan_on = 1'b1;
              frm_d.tcap    = '0;
              frm_d.rcap    = '0;
              phase_d       = PH_KEY;
            end else begin
              if (frm_d.sc == SC_PRED && count_d != '0) begin
                count_d = count_d + 32'd1;
              end
              phase_d = PH_SKIP;
            end
          end
          hit_end = (frm_d.left == '0);
        end
        PH_KEY: begin
          if (frm_d.tcap != 2'd0) begin
            frm_d.hdr  = {40'h0, frm_d.hdr[15:0], in_byte_i};
            frm_d.tcap = frm_d.tcap - 2'd1;
            if (frm_d.tcap == 2'd0) begin
              t0           = frm_d.hdr[23:16];
              t1           = frm_d.hdr[15:8];
              t2           = frm_d.hdr[7:0];
              ent_d.hour   = {1'b0, t0[7:3]} + 6'd1;
              ent_d.minute = {1'b0, t0[2:0], t1[7:5]} + 7'd1;
              ent_d.second = {1'b0, t1[3:0], t2[7:6]} + 7'd1;
            end
          end
          if (frm_d.rcap != 3'd0) begin
            frm_d.rcap = frm_d.rcap - 3'd1;
            if (frm_d.rcap == 3'd0) begin
              if (in_byte_i > RATE_MAX) begin
                ent_d.rate = (in_byte_i == RATE_WILD) ? RATE_WILD_FPS : RATE_DEFAULT_FPS;
              end else begin
                ent_d.rate = in_byte_i;
              end
            end
          end
          if (frm_d.scan_on && (off < 32'(HEADER_WINDOW))) begin
            frm_d.sc = {frm_d.sc[23:0], in_byte_i};
            priority if (frm_d.sc == SC_TIME) begin
              frm_d.tcap = 2'd3;
              frm_d.hdr  = '0;
            end else if (frm_d.sc == SC_RATE) begin
              frm_d.rcap = 3'd7;
            end else if (frm_d.sc == SC_PRED) begin
              frm_d.scan_on = 1'b0;
            end else begin
            end
          end
          frm_d.left = frm_d.left - 32'd1;
          hit_end    = (frm_d.left == '0);
        end
        PH_SKIP: begin
          frm_d.left = frm_d.left - 32'd1;
          hit_end    = (frm_d.left == '0);
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    if (hit_end) begin
      key_out                = (phase_d == PH_KEY);
      key_rec.kind           = KIND_KEY;
      key_rec.frame_position = frm_d.start;
      key_rec.frame_number   = ent_d.num;
      key_rec.frame_length   = pos_d - frm_d.start + 32'd1;
      key_rec.hour_code      = ent_d.hour;
      key_rec.minute_code    = ent_d.minute;
      key_rec.second_code    = ent_d.second;
      key_rec.frame_rate     = ent_d.rate;
      next_pos = {1'b0, pos_d} + 33'd1;
      if (next_pos[32] || !fits(next_pos, stream_length_i)) begin
        fin = 1'b1;
      end else begin
        frm_d   = fresh_frame(next_pos[31:0]);
        phase_d = PH_HEADER;
      end
    end

    if (fin) begin
      phase_d = PH_IDLE;
    end

    fin_rec              = '0;
    fin_rec.kind         = (count_d != '0) ? KIND_DONE : KIND_NO_FRAMES;
    fin_rec.total_frames = count_d;
    bad_rec              = '0;
    bad_rec.kind         = KIND_BAD_TAG;

    push_o.first  = key_out ? key_rec : (bad_tag ? bad_rec : fin_rec);
    push_o.second = fin_rec;
    push_o.count  = {1'b0, key_out} + {1'b0, bad_tag} + {1'b0, fin};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      count_q <= '0;
      frm_q   <= fresh_frame('0);
      ent_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      frm_q   <= frm_d;
      ent_q   <= ent_d;
    end
  end

endmodule

// ===== rtl/keyframe_index_builder_top.sv =====
// ----------------------------------------------------------------------------
// Keyframe index builder
// The block takes one stream byte per beat and sustains one byte per clock
// while the input is ready. A byte is parsed while it sits in the input
// register, so its results enter the 8-entry result queue at the clock edge
// after the byte beat. Results leave on the output stream one record per
// beat. The input is ready while the queue holds four records or fewer;
// that queue depth is what sets how long the output side may stall before
// input beats stop. A pass starts with a byte flagged first_byte. Write the
// stream length and start offset registers only while no pass is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "keyframe_index_builder_top_assert.svh"

module keyframe_index_builder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] data_byte
  input  logic [7:0]                      s_axis_tdata_i,
  // [0] first_byte
  input  logic [0:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] frame_position, [63:32] frame_number, [95:64] frame_length,
  // [101:96] hour_code, [108:102] minute_code, [115:109] second_code,
  // [123:116] frame_rate, [155:124] total_frames, [159:156] zero
  output logic [kib_pkg::TDATA_W-1:0]     m_axis_tdata_o,
  // [1:0] kind
  output logic [1:0]                      m_axis_tuser_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kib_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import kib_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_first_q;
  logic [31:0] stream_length_q;
  logic [31:0] start_offset_q;
  logic        in_accept;
  logic        res_pop;
  res_push_t   core_push;
  result_t     head;
  fifo_stat_t  fifo_stat;
  logic [RES_CW:0] level_next;
  logic        push_any;
  logic        pair_kinds_ok;

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (fifo_stat.level <= RES_CW'(IN_SLACK));
  assign cfg_ready_o     = 1'b1;
  assign res_pop         = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_length_q <= '0;
      start_offset_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STREAM_LENGTH: stream_length_q <= cfg_data_i;
        REG_START_OFFSET:  start_offset_q  <= cfg_data_i;
      endcase
    end
  end

  kib_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_vld_q),
    .in_byte_i       (in_byte_q),
    .in_first_i      (in_first_q),
    .stream_length_i (stream_length_q),
    .start_offset_i  (start_offset_q),
    .push_o          (core_push)
  );

  kib_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_push),
    .pop_i   (res_pop),
    .head_o  (head),
    .valid_o (m_axis_tvalid_o),
    .stat_o  (fifo_stat)
  );

  assign m_axis_tdata_o = {{(TDATA_W - RES_DATA_W){1'b0}},
                           head.total_frames, head.frame_rate, head.second_code,
                           head.minute_code, head.hour_code, head.frame_length,
                           head.frame_number, head.frame_position};
  assign m_axis_tuser_o = head.kind;

  assign level_next    = (RES_CW+1)'(fifo_stat.level) + (RES_CW+1)'(core_push.count)
                         - (RES_CW+1)'(res_pop);
  assign push_any      = (core_push.count != 2'd0);
  assign pair_kinds_ok = (core_push.first.kind == KIND_KEY)
                         && (core_push.second.kind != KIND_KEY);

  // The queue keeps enough room for every record the parser can produce.
  `KIB_ASSERT(a_queue_no_overflow, clk_i, rst_ni, level_next <= (RES_CW+1)'(RES_DEPTH))
  // Two records from one byte are always a key entry followed by the pass end.
  `KIB_ASSERT_IMPL(a_pair_entry_then_end, clk_i, rst_ni, core_push.count == 2'd2, pair_kinds_ok)
  // Output data only appears after the parser has queued a record.
  `KIB_ASSERT_IMPL(a_output_from_push, clk_i, rst_ni, $rose(m_axis_tvalid_o), $past(push_any))

endmodule
